/* src/smi_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the small matrix inverse: default word format, matrix
// order codes and the cofactor index tables. Depends on nothing.
package smi_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int N_ELEM        = 9;

    typedef logic [1:0] msize_t;

    localparam msize_t SIZE_NONE = 2'd0;
    localparam msize_t SIZE_1    = 2'd1;
    localparam msize_t SIZE_2    = 2'd2;
    localparam msize_t SIZE_3    = 2'd3;

    // Adjugate entry k of an order-3 matrix is m[A]*m[B] - m[C]*m[D], row-major indices.
    localparam int COF_A [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int COF_B [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int COF_C [N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int COF_D [N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

/* src/small_matrix_inverse.sv */
`timescale 1ns / 1ps
// Pipelined determinant and inverse of a square matrix of order 1, 2 or 3.
// Depends on smi_pkg for the word format, order codes and cofactor tables.

// The block takes one matrix in every cycle: busy is never high, so a word is
// taken at each clock edge with start high. The result of a word comes out on
// the done strobe, for one cycle only, since the receiver cannot stall the
// block. The pipeline depth is set by the nine dividers of the inverse, which
// produce one quotient bit per pipeline stage; cofactors, determinant and
// rounding take the first eight stages. Results keep the order of the words. A
// zero determinant, or an order of zero, gives singular high with a zero
// inverse and a zero determinant.
module small_matrix_inverse #(
    parameter int WORD_BITS = smi_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = smi_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  size,
    input  logic signed [WORD_BITS-1:0] m00,
    input  logic signed [WORD_BITS-1:0] m01,
    input  logic signed [WORD_BITS-1:0] m02,
    input  logic signed [WORD_BITS-1:0] m10,
    input  logic signed [WORD_BITS-1:0] m11,
    input  logic signed [WORD_BITS-1:0] m12,
    input  logic signed [WORD_BITS-1:0] m20,
    input  logic signed [WORD_BITS-1:0] m21,
    input  logic signed [WORD_BITS-1:0] m22,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] inv00,
    output logic signed [WORD_BITS-1:0] inv01,
    output logic signed [WORD_BITS-1:0] inv02,
    output logic signed [WORD_BITS-1:0] inv10,
    output logic signed [WORD_BITS-1:0] inv11,
    output logic signed [WORD_BITS-1:0] inv12,
    output logic signed [WORD_BITS-1:0] inv20,
    output logic signed [WORD_BITS-1:0] inv21,
    output logic signed [WORD_BITS-1:0] inv22,
    output logic signed [WORD_BITS-1:0] det_value,
    output logic                        singular
);

    localparam int W      = WORD_BITS;
    localparam int F      = FRAC_BITS;
    localparam int NE     = smi_pkg::N_ELEM;
    localparam int PROD_W = 2 * W;
    localparam int ADJ_W  = 2 * W + 1;
    localparam int ADJM_W = 2 * W;
    localparam int PART_W = 2 * W + 1;
    localparam int DET_W  = 3 * W + 2;
    localparam int MAG_W  = 3 * W + 1;
    localparam int DEN_W  = 3 * W + 2;
    localparam int RND_W  = MAG_W + 1;
    localparam int SH_W   = 2 * F + 1;
    localparam int NUM_W  = ((ADJM_W + SH_W) > MAG_W ? (ADJM_W + SH_W) : MAG_W) + 1;
    localparam int HI_W   = NUM_W - W;
    localparam int CMP_W  = (HI_W > DEN_W) ? HI_W : DEN_W;
    localparam int NSTAGE = W + 10;

    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

    logic [NSTAGE-1:0] vld_reg;

    logic signed [W-1:0] m_in [0:NE-1];

    logic signed [W-1:0]      m0_reg [0:NE-1];
    smi_pkg::msize_t          size0_reg;

    logic signed [PROD_W-1:0] prod_a_reg [0:NE-1];
    logic signed [PROD_W-1:0] prod_b_reg [0:NE-1];
    logic signed [W-1:0]      e1_reg [0:4];
    smi_pkg::msize_t          size1_reg;

    logic signed [ADJ_W-1:0]  diff3 [0:NE-1];
    logic signed [ADJ_W-1:0]  adj_next [0:NE-1];
    logic signed [ADJ_W-1:0]  adj2_reg [0:NE-1];
    logic signed [W-1:0]      e2_reg [0:2];
    smi_pkg::msize_t          size2_reg;

    logic [ADJ_W-1:0]         adj_abs [0:NE-1];
    logic signed [PART_W-1:0] plo_reg [0:2];
    logic signed [PART_W-1:0] phi_reg [0:2];
    logic [ADJM_W-1:0]        adjmag3_reg [0:NE-1];
    logic [NE-1:0]            adjneg3_reg;
    smi_pkg::msize_t          size3_reg;

    logic signed [DET_W-1:0]  term_reg [0:2];
    logic [ADJM_W-1:0]        adjmag4_reg [0:NE-1];
    logic [NE-1:0]            adjneg4_reg;
    smi_pkg::msize_t          size4_reg;

    logic signed [DET_W-1:0]  det5_reg;
    logic [ADJM_W-1:0]        adjmag5_reg [0:NE-1];
    logic [NE-1:0]            adjneg5_reg;
    smi_pkg::msize_t          size5_reg;

    logic [DET_W-1:0]         det_abs;
    logic [MAG_W-1:0]         detmag6_reg;
    logic                     detneg6_reg;
    logic                     sing6_reg;
    logic [ADJM_W-1:0]        adjmag6_reg [0:NE-1];
    logic [NE-1:0]            adjneg6_reg;
    smi_pkg::msize_t          size6_reg;

    logic [RND_W-1:0]         det_rnd;
    logic [W-1:0]             detv_next;
    logic [NUM_W-1:0]         num7_reg [0:NE-1];
    logic [DEN_W-1:0]         den7_reg;
    logic [NE-1:0]            neg7_reg;
    logic                     sing7_reg;
    logic [W-1:0]             detv7_reg;

    logic [DEN_W-1:0]         rem_reg  [0:W][0:NE-1];
    logic [W-1:0]             nlo_reg  [0:W][0:NE-1];
    logic [W-1:0]             q_reg    [0:W][0:NE-1];
    logic [NE-1:0]            big_reg  [0:W];
    logic [NE-1:0]            neg_reg  [0:W];
    logic [DEN_W-1:0]         den_reg  [0:W];
    logic                     sing_reg [0:W];
    logic [W-1:0]             detv_reg [0:W];

    logic [DEN_W-1:0]         rem_next [1:W][0:NE-1];
    logic [W-1:0]             q_next   [1:W][0:NE-1];

    logic [W-1:0]             inv_next [0:NE-1];
    logic [W-1:0]             inv_reg  [0:NE-1];
    logic [W-1:0]             detv_out_reg;
    logic                     sing_out_reg;

    assign m_in[0] = m00;
    assign m_in[1] = m01;
    assign m_in[2] = m02;
    assign m_in[3] = m10;
    assign m_in[4] = m11;
    assign m_in[5] = m12;
    assign m_in[6] = m20;
    assign m_in[7] = m21;
    assign m_in[8] = m22;

    // Nothing ever holds the pipeline, so a word is taken on every start.
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NSTAGE-2:0], start};
        end
    end

    // Input stage, the eighteen cofactor products, adjugate magnitudes and numerators.
    genvar k;
    generate
        for (k = 0; k < NE; k++)
        begin : g_elem
            always_ff @(posedge clk)
            begin
                m0_reg[k]     <= m_in[k];
                prod_a_reg[k] <= m0_reg[smi_pkg::COF_A[k]] * m0_reg[smi_pkg::COF_B[k]];
                prod_b_reg[k] <= m0_reg[smi_pkg::COF_C[k]] * m0_reg[smi_pkg::COF_D[k]];
                adj2_reg[k]   <= adj_next[k];
            end

            assign diff3[k] = ADJ_W'(prod_a_reg[k]) - ADJ_W'(prod_b_reg[k]);
            assign adj_abs[k] = adj2_reg[k][ADJ_W-1] ? ADJ_W'(-adj2_reg[k]) : adj2_reg[k];

            always_ff @(posedge clk)
            begin
                adjmag3_reg[k] <= adj_abs[k][ADJM_W-1:0];
                adjneg3_reg[k] <= adj2_reg[k][ADJ_W-1];
                adjmag4_reg[k] <= adjmag3_reg[k];
                adjneg4_reg[k] <= adjneg3_reg[k];
                adjmag5_reg[k] <= adjmag4_reg[k];
                adjneg5_reg[k] <= adjneg4_reg[k];
                adjmag6_reg[k] <= adjmag5_reg[k];
                adjneg6_reg[k] <= adjneg5_reg[k];
                num7_reg[k]    <= (NUM_W'(adjmag6_reg[k]) << SH_W) + NUM_W'(detmag6_reg);
                neg7_reg[k]    <= adjneg6_reg[k] ^ detneg6_reg;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        size0_reg <= size;
        size1_reg <= size0_reg;
        e1_reg[0] <= m0_reg[0];
        e1_reg[1] <= m0_reg[1];
        e1_reg[2] <= m0_reg[2];
        e1_reg[3] <= m0_reg[3];
        e1_reg[4] <= m0_reg[4];
        size2_reg <= size1_reg;
        e2_reg[0] <= e1_reg[0];
        e2_reg[1] <= e1_reg[1];
        e2_reg[2] <= e1_reg[2];
        size3_reg <= size2_reg;
        size4_reg <= size3_reg;
        size5_reg <= size4_reg;
        size6_reg <= size5_reg;
    end

    // Adjugate by order. Entries outside the leading block stay zero, which
    // makes the determinant row 0 times column 0 of the adjugate for every order.
    always_comb
    begin
        for (int i = 0; i < NE; i++)
        begin
            adj_next[i] = '0;
        end
        case (size1_reg)
            smi_pkg::SIZE_3:
            begin
                for (int i = 0; i < NE; i++)
                begin
                    adj_next[i] = diff3[i];
                end
            end
            smi_pkg::SIZE_2:
            begin
                adj_next[0] = ADJ_W'(e1_reg[4]);
                adj_next[1] = -ADJ_W'(e1_reg[1]);
                adj_next[3] = -ADJ_W'(e1_reg[3]);
                adj_next[4] = ADJ_W'(e1_reg[0]);
            end
            smi_pkg::SIZE_1:
            begin
                adj_next[0] = ADJ_W'(1);
            end
            default:
            begin
                adj_next[0] = '0;
            end
        endcase
    end

    // Each wide product is split at word W into two narrower multiplies.
    genvar j;
    generate
        for (j = 0; j < 3; j++)
        begin : g_det
            always_ff @(posedge clk)
            begin
                plo_reg[j]  <= e2_reg[j] * $signed({1'b0, adj2_reg[3*j][W-1:0]});
                phi_reg[j]  <= e2_reg[j] * $signed(adj2_reg[3*j][ADJ_W-1:W]);
                term_reg[j] <= DET_W'(plo_reg[j]) + (DET_W'(phi_reg[j]) <<< W);
            end
        end
    endgenerate

    assign det_abs = det5_reg[DET_W-1] ? DET_W'(-det5_reg) : det5_reg;

    // Determinant rounded to nearest, ties away from zero, then saturated.
    always_comb
    begin
        case (size6_reg)
            smi_pkg::SIZE_3:
            begin
                det_rnd = (RND_W'(detmag6_reg) + (RND_W'(1) << (2*F-1))) >> (2*F);
            end
            smi_pkg::SIZE_2:
            begin
                det_rnd = (RND_W'(detmag6_reg) + (RND_W'(1) << (F-1))) >> F;
            end
            default:
            begin
                det_rnd = RND_W'(detmag6_reg);
            end
        endcase
        if (!detneg6_reg)
        begin
            detv_next = (det_rnd > RND_W'(MAX_POS)) ? MAX_POS : det_rnd[W-1:0];
        end
        else
        begin
            detv_next = (det_rnd > RND_W'(MIN_NEG)) ? MIN_NEG : W'(-det_rnd[W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        det5_reg    <= term_reg[0] + term_reg[1] + term_reg[2];
        detmag6_reg <= det_abs[MAG_W-1:0];
        detneg6_reg <= det5_reg[DET_W-1];
        sing6_reg   <= (det5_reg == '0) || (size5_reg == smi_pkg::SIZE_NONE);
        den7_reg    <= {detmag6_reg, 1'b0};
        sing7_reg   <= sing6_reg;
        detv7_reg   <= detv_next;
    end

    // Divider entry: a quotient that cannot fit in W bits saturates.
    generate
        for (k = 0; k < NE; k++)
        begin : g_div0
            always_ff @(posedge clk)
            begin
                rem_reg[0][k] <= CMP_W'(num7_reg[k] >> W)
                                 >= CMP_W'(den7_reg) ? '0 : DEN_W'(num7_reg[k] >> W);
                big_reg[0][k] <= CMP_W'(num7_reg[k] >> W) >= CMP_W'(den7_reg);
                nlo_reg[0][k] <= num7_reg[k][W-1:0];
                q_reg[0][k]   <= '0;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        neg_reg[0]  <= neg7_reg;
        den_reg[0]  <= den7_reg;
        sing_reg[0] <= sing7_reg;
        detv_reg[0] <= detv7_reg;
    end

    // One restoring quotient bit per stage; the remainder stays below the divisor.
    genvar s;
    generate
        for (s = 1; s <= W; s++)
        begin : g_stage
            for (k = 0; k < NE; k++)
            begin : g_lane
                logic [DEN_W:0] trial;

                assign trial = {rem_reg[s-1][k], nlo_reg[s-1][k][W-1]};

                always_comb
                begin
                    if (trial >= {1'b0, den_reg[s-1]})
                    begin
                        rem_next[s][k] = DEN_W'(trial - {1'b0, den_reg[s-1]});
                        q_next[s][k]   = {q_reg[s-1][k][W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[s][k] = trial[DEN_W-1:0];
                        q_next[s][k]   = {q_reg[s-1][k][W-2:0], 1'b0};
                    end
                end

                always_ff @(posedge clk)
                begin
                    rem_reg[s][k] <= rem_next[s][k];
                    q_reg[s][k]   <= q_next[s][k];
                    nlo_reg[s][k] <= {nlo_reg[s-1][k][W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                big_reg[s]  <= big_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                den_reg[s]  <= den_reg[s-1];
                sing_reg[s] <= sing_reg[s-1];
                detv_reg[s] <= detv_reg[s-1];
            end
        end
    endgenerate

    generate
        for (k = 0; k < NE; k++)
        begin : g_out
            always_comb
            begin
                if (sing_reg[W])
                begin
                    inv_next[k] = '0;
                end
                else if (!neg_reg[W][k])
                begin
                    inv_next[k] = (big_reg[W][k] || (q_reg[W][k] > MAX_POS))
                                  ? MAX_POS : q_reg[W][k];
                end
                else
                begin
                    inv_next[k] = (big_reg[W][k] || (q_reg[W][k] > MIN_NEG))
                                  ? MIN_NEG : W'(-q_reg[W][k]);
                end
            end

            always_ff @(posedge clk)
            begin
                inv_reg[k] <= inv_next[k];
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        detv_out_reg <= sing_reg[W] ? '0 : detv_reg[W];
        sing_out_reg <= sing_reg[W];
    end

    assign done      = vld_reg[NSTAGE-1];
    assign inv00     = inv_reg[0];
    assign inv01     = inv_reg[1];
    assign inv02     = inv_reg[2];
    assign inv10     = inv_reg[3];
    assign inv11     = inv_reg[4];
    assign inv12     = inv_reg[5];
    assign inv20     = inv_reg[6];
    assign inv21     = inv_reg[7];
    assign inv22     = inv_reg[8];
    assign det_value = detv_out_reg;
    assign singular  = sing_out_reg;

    // Every result strobe has a matching input word that was taken with start high.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, NSTAGE))
        else $error("result strobe without a matching input word");

    // A singular result carries a zero determinant and zero inverse entries 00, 01, 11 and 22.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && singular) |-> (det_value == '0 && inv00 == '0 && inv11 == '0
                                && inv22 == '0 && inv01 == '0))
        else $error("singular result with non-zero fields");

endmodule
